@@ design/upd_pkg.sv @@
// Package for the URL percent decoder: phase codes, characters and the hex digit decoder.
`timescale 1ns / 1ps

package upd_pkg;

    // Decoder phase, one-hot coded.
    typedef enum logic [3:0] {
        PH_NORMAL  = 4'b0001,
        PH_PERCENT = 4'b0010,
        PH_HIGH    = 4'b0100,
        PH_DROP    = 4'b1000
    } phase_t;

    // Characters with a special meaning in a URL.
    localparam logic [7:0] CHAR_PERCENT  = 8'h25;
    localparam logic [7:0] CHAR_PLUS     = 8'h2b;
    localparam logic [7:0] CHAR_QUESTION = 8'h3f;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F  = 8'h66;
    localparam logic [7:0] HEX_TEN       = 8'h0a;

    // Result of decoding one hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Decodes one ASCII hex digit of either case; value is zero when not a digit.
    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t       h;
        logic [7:0] diff;
        h    = '0;
        diff = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
            h.ok = 1'b1;
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            diff = c - CHAR_UPPER_A + HEX_TEN;
            h.ok = 1'b1;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            diff = c - CHAR_LOWER_A + HEX_TEN;
            h.ok = 1'b1;
        end
        h.value = diff[3:0];
        return h;
    endfunction

endpackage

@@ design/url_percent_decoder.sv @@
// URL percent decoder: one byte per beat in, zero or one decoded byte per beat out.
// Path: an accepted input beat is held in the input register, its result in the
// result register. Throughput: one byte per cycle unless a held result waits on
// result_ready; the per-byte phase logic sits between the input and result registers.
// Reset: asynchronous, active low; clears the valid bits of both registers, the phase
// state and start_query_reg.
`timescale 1ns / 1ps

module url_percent_decoder
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // Input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    // Result channel
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       out_last,
    output logic       out_error
);

    // Input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // Decoder state
    phase_t     phase_reg, phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       high_ok_reg, high_ok_next;
    logic       query_reg, query_next;
    logic       start_query_reg;

    // Result register
    logic       res_valid_reg;
    logic [7:0] res_byte_reg;
    logic       res_dvalid_reg;
    logic       res_last_reg;
    logic       res_error_reg;

    // Result of the current byte
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_dvalid;
    logic       emit_last;
    logic       emit_error;
    hex_t       hex;
    logic       advance;

    assign cfg_ready = 1'b1;
    assign hex       = hex_digit(s1_byte_reg);

    // Per-byte phase logic.
    always_comb
    begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        high_ok_next     = high_ok_reg;
        query_next       = query_reg;
        emit             = 1'b0;
        emit_byte        = '0;
        emit_dvalid      = 1'b0;
        emit_last        = s1_last_reg;
        emit_error       = 1'b0;
        unique case (phase_reg)
            PH_NORMAL:
            begin
                if (s1_byte_reg == CHAR_PERCENT) begin
                    if (s1_last_reg) begin
                        emit = 1'b1;
                    end else begin
                        phase_next = PH_PERCENT;
                    end
                end else if (query_reg && s1_byte_reg == CHAR_PLUS) begin
                    emit        = 1'b1;
                    emit_byte   = CHAR_SPACE;
                    emit_dvalid = 1'b1;
                end else begin
                    if (s1_byte_reg == CHAR_QUESTION) begin
                        query_next = 1'b1;
                    end
                    emit        = 1'b1;
                    emit_byte   = s1_byte_reg;
                    emit_dvalid = 1'b1;
                end
            end
            PH_PERCENT:
            begin
                if (s1_last_reg) begin
                    emit = 1'b1;
                end else begin
                    high_ok_next     = hex.ok;
                    high_nibble_next = hex.value;
                    phase_next       = PH_HIGH;
                end
            end
            PH_HIGH:
            begin
                emit = 1'b1;
                if (hex.ok && high_ok_reg) begin
                    emit_byte   = {high_nibble_reg, hex.value};
                    emit_dvalid = 1'b1;
                    phase_next  = PH_NORMAL;
                end else begin
                    emit_error = 1'b1;
                    phase_next = PH_DROP;
                end
                high_nibble_next = '0;
                high_ok_next     = 1'b0;
            end
            PH_DROP:
            begin
                if (s1_last_reg) begin
                    emit       = 1'b1;
                    emit_error = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_NORMAL;
            end
        endcase
        // The last byte of a string returns the state to its start values.
        if (s1_last_reg) begin
            phase_next       = PH_NORMAL;
            high_nibble_next = '0;
            high_ok_next     = 1'b0;
            query_next       = start_query_reg;
        end
    end

    // The held byte moves on when it gives no result or the result register frees up.
    assign advance  = s1_valid_reg && (!emit || !res_valid_reg || result_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

    // Decoder state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_NORMAL;
            high_nibble_reg <= '0;
            high_ok_reg     <= 1'b0;
            query_reg       <= 1'b0;
            start_query_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            start_query_reg <= cfg_data;
            query_reg       <= cfg_data;
        end else if (advance) begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            high_ok_reg     <= high_ok_next;
            query_reg       <= query_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            res_valid_reg <= 1'b1;
        end else if (result_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit) begin
            res_byte_reg   <= emit_byte;
            res_dvalid_reg <= emit_dvalid;
            res_last_reg   <= emit_last;
            res_error_reg  <= emit_error;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_byte     = res_byte_reg;
    assign out_valid    = res_dvalid_reg;
    assign out_last     = res_last_reg;
    assign out_error    = res_error_reg;

endmodule

@@ bench/url_percent_decoder_tb.sv @@
// Testbench for the URL percent decoder: directed and random strings, register writes and a scoreboard.
`timescale 1ns / 1ps

module url_percent_decoder_tb
    import upd_pkg::*;
();

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 40;

    // Keeps its own copy of the decoder state and the queue of decoded bytes still due.
    class url_decode_scoreboard;
        typedef struct packed {
            logic [7:0] data;
            logic       valid;
            logic       last;
            logic       err;
        } decoded_t;

        decoded_t   expected_bytes[$];
        logic       query_start;
        phase_t     phase;
        logic [3:0] hi_nibble;
        logic       hi_ok;
        logic       query_on;
        int         fail_count;

        function new();
            query_start = 1'b0;
            fail_count  = 0;
            end_of_string();
        endfunction

        // Gives the value of an ASCII hex digit of either case in v and returns 1; returns 0 for anything else.
        static function bit hex_of(input logic [7:0] c, output logic [3:0] v);
            v = 4'h0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                v = 4'(c - CHAR_ZERO);
                return 1'b1;
            end
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
                v = 4'(c - CHAR_UPPER_A + 8'd10);
                return 1'b1;
            end
            if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
                v = 4'(c - CHAR_LOWER_A + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void end_of_string();
            phase     = PH_NORMAL;
            hi_nibble = 4'h0;
            hi_ok     = 1'b0;
            query_on  = query_start;
        endfunction

        // A register write also switches the query mode of the current string.
        function void set_query_mode(input logic v);
            query_start = v;
            query_on    = v;
        endfunction

        function int pending_count();
            return expected_bytes.size();
        endfunction

        // Advances the decoder by one accepted input beat and queues its result, if any.
        function void decode_byte(input logic [7:0] c, input logic is_last);
            decoded_t   r;
            logic [3:0] v;
            bit         ok;
            bit         emit;
            r    = '0;
            emit = 1'b0;
            case (phase)
                PH_NORMAL:
                begin
                    if (c == CHAR_PERCENT) begin
                        if (is_last) begin
                            r.last = 1'b1;
                            emit   = 1'b1;
                        end else begin
                            phase = PH_PERCENT;
                        end
                    end else if (query_on && c == CHAR_PLUS) begin
                        r.data  = CHAR_SPACE;
                        r.valid = 1'b1;
                        r.last  = is_last;
                        emit    = 1'b1;
                    end else begin
                        if (c == CHAR_QUESTION)
                            query_on = 1'b1;
                        r.data  = c;
                        r.valid = 1'b1;
                        r.last  = is_last;
                        emit    = 1'b1;
                    end
                end
                PH_PERCENT:
                begin
                    // A string that ends right after the percent sign closes quietly.
                    if (is_last) begin
                        r.last = 1'b1;
                        emit   = 1'b1;
                    end else begin
                        hi_ok     = hex_of(c, v);
                        hi_nibble = v;
                        phase     = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    ok = hex_of(c, v);
                    if (ok && hi_ok) begin
                        r.data  = {hi_nibble, v};
                        r.valid = 1'b1;
                        phase   = PH_NORMAL;
                    end else begin
                        r.err = 1'b1;
                        phase = PH_DROP;
                    end
                    r.last    = is_last;
                    emit      = 1'b1;
                    hi_nibble = 4'h0;
                    hi_ok     = 1'b0;
                end
                default:
                begin
                    // The rest of an invalid string is dropped; only its close is reported.
                    if (is_last) begin
                        r.last = 1'b1;
                        r.err  = 1'b1;
                        emit   = 1'b1;
                    end
                end
            endcase
            if (emit)
                expected_bytes = {expected_bytes, r};
            if (is_last)
                end_of_string();
        endfunction

        function void flag(input string field, input logic [7:0] want, input logic [7:0] got);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s mismatch: expected %0h, actual %0h", field, want, got);
        endfunction

        // Compares one result beat with the oldest decoded byte still due.
        function void check_beat(input logic [7:0] data, input logic valid,
                                 input logic last_flag, input logic err);
            decoded_t want;
            if (expected_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("result beat with nothing expected: out_byte %0h", data);
                return;
            end
            want = expected_bytes.pop_front();
            if (want.data !== data)
                flag("out_byte", want.data, data);
            if (want.valid !== valid)
                flag("out_valid", 8'(want.valid), 8'(valid));
            if (want.last !== last_flag)
                flag("out_last", 8'(want.last), 8'(last_flag));
            if (want.err !== err)
                flag("out_error", 8'(want.err), 8'(err));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       out_error;

    url_decode_scoreboard sb;
    int  items_sent    = 0;
    int  cycle_count   = 0;
    bit  calm          = 1'b0;
    bit  hold_request  = 1'b0;

    url_percent_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .out_valid    (out_valid),
        .out_last     (out_last),
        .out_error    (out_error)
    );

    always #(CLK_HALF) clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Every accepted result beat goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid && result_ready)
            sb.check_beat(out_byte, out_valid, out_last, out_error);
    end

    // Gap length: mostly none, sometimes short, rarely long; none in calm stretches.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return CHAR_ZERO + 8'(n);
        return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] v;
        c = 8'($urandom_range(0, 255));
        while (url_decode_scoreboard::hex_of(c, v))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int stall;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = pick_gap();
            if (stall > 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    // Offers one input beat, waits for it to be taken, then maybe idles.
    task automatic send_beat(input logic [7:0] c, input logic is_last);
        int gap;
        in_valid <= 1'b1;
        in_byte  <= c;
        in_last  <= is_last;
        do @(posedge clk); while (!in_ready);
        sb.decode_byte(c, is_last);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], close && (i == s.len() - 1));
    endtask

    // Stops sending and waits until every due result has come and the pipeline is empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_count() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_query_mode(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_query_mode(v);
    endtask

    // Builds one random string, mostly well formed, and sends it.
    task automatic send_url();
        logic [7:0] text[$];
        int         tokens;
        int         kind;
        logic [7:0] c;
        tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
        if ($urandom_range(0, 9) == 0) begin
            // Pure noise.
            repeat (tokens) text = {text, 8'($urandom_range(0, 255))};
        end else begin
            repeat (tokens) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    c = 8'($urandom_range(33, 126));
                    text = {text, (c == CHAR_PERCENT) ? CHAR_ZERO : c};
                end else if (kind < 40) begin
                    text = {text, CHAR_PLUS};
                end else if (kind < 45) begin
                    text = {text, CHAR_QUESTION};
                end else if (kind < 70) begin
                    text = {text, CHAR_PERCENT};
                    text = {text, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)))};
                    text = {text, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)))};
                end else if (kind < 76) begin
                    // Escape with at least one bad digit.
                    text = {text, CHAR_PERCENT};
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            text = {text, non_hex_char()};
                            text = {text, hex_char(4'($urandom_range(0, 15)), 1'b0)};
                        end
                        1:
                        begin
                            text = {text, hex_char(4'($urandom_range(0, 15)), 1'b1)};
                            text = {text, non_hex_char()};
                        end
                        default:
                        begin
                            text = {text, non_hex_char()};
                            text = {text, non_hex_char()};
                        end
                    endcase
                end else begin
                    text = {text, 8'($urandom_range(0, 255))};
                end
            end
            // Sometimes the string ends inside an escape.
            if ($urandom_range(0, 11) == 0) begin
                text = {text, CHAR_PERCENT};
                if ($urandom_range(0, 1))
                    text = {text, 8'($urandom_range(0, 255))};
            end
        end
        for (int i = 0; i < text.size(); i++) begin
            send_beat(text[i], i == text.size() - 1);
            // Rare register write in the middle of a string.
            if (i != text.size() - 1 && $urandom_range(0, 199) == 0) begin
                wait_drained();
                load_query_mode(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin : stimulus
        int next_cfg_at;
        bit hold_done;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        in_valid  <= 1'b0;
        in_byte   <= 8'h00;
        in_last   <= 1'b0;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, query mode off after reset.
        send_text("a+?+", 1'b1);
        send_text("%41%fF%00", 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b1);
        // High digit at or above 0x80, then the dropped tail.
        send_text("%", 1'b0);
        send_beat(8'hc3, 1'b0);
        send_text("1x", 1'b1);
        // Bad second digit on the closing byte.
        send_text("%4z", 1'b1);
        // Escapes cut short by the end of the string.
        send_text("%", 1'b1);
        send_text("%4", 1'b1);
        wait_drained();
        load_query_mode(1'b1);
        send_text("+", 1'b1);
        // Query mode switched off in the middle of a string.
        send_text("a", 1'b0);
        wait_drained();
        load_query_mode(1'b0);
        send_text("+", 1'b1);
        wait_drained();

        // Random part, in phases separated by register writes.
        next_cfg_at = items_sent;
        hold_done   = 1'b0;
        items_sent  = 0;
        next_cfg_at = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= next_cfg_at) begin
                wait_drained();
                load_query_mode(1'($urandom_range(0, 1)));
                calm        = ($urandom_range(0, 3) == 0);
                next_cfg_at = next_cfg_at + $urandom_range(100, 200);
            end
            if (!hold_done && items_sent >= 400) begin
                calm         = 1'b0;
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            send_url();
        end

        wait_drained();
        if (sb.fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
